// File: design/rdc_pkg.sv
// Shared types, constants and helpers for the radix digit converter.
// No dependencies.
package rdc_pkg;

  localparam int VALUE_BITS = 30;
  localparam int RADIX_BITS = 5;
  localparam int DIGIT_BITS = 4;
  localparam int CHAR_BITS  = 7;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(48);  // '0'
  localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = CHAR_BITS'(55);  // 'A' - 10

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
  } item_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit_value;
    logic [CHAR_BITS-1:0]  digit_char;
    logic                  last_digit;
  } digit_t;

  // Controls broadcast to every cell of the row.
  typedef struct packed {
    logic                  clear;
    logic                  conv;
    logic                  shift;
    logic [RADIX_BITS-1:0] radix;
  } cell_ctl_t;

  function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] res;
    if (d < DIGIT_BITS'(10)) res = CHAR_ZERO + CHAR_BITS'(d);
    else                     res = CHAR_ALPHA + CHAR_BITS'(d);
    return res;
  endfunction

endpackage

// File: design/rdc_cell.sv
// One digit cell of the conversion row: holds a base-r digit, doubles it and
// adds the carry from its lower neighbor, registering its own carry upward.
// Depends on rdc_pkg.
module rdc_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  rdc_pkg::cell_ctl_t             ctl,
  input  logic                           en_in,
  input  logic                           carry_in,
  input  logic [rdc_pkg::DIGIT_BITS-1:0] digit_in,
  output logic [rdc_pkg::DIGIT_BITS-1:0] digit,
  output logic                           en_out,
  output logic                           carry_out
);

  logic [rdc_pkg::RADIX_BITS-1:0] dbl;
  logic                           ge;
  logic [rdc_pkg::RADIX_BITS-1:0] dbl_red;

  // digit < radix holds, so 2*digit+carry < 2*radix and one subtract suffices
  assign dbl     = {1'b0, digit} + {1'b0, digit} + rdc_pkg::RADIX_BITS'(carry_in);
  assign ge      = (dbl >= ctl.radix);
  assign dbl_red = ge ? (dbl - ctl.radix) : dbl;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_out    <= 1'b0;
      carry_out <= 1'b0;
    end else if (ctl.clear) begin
      en_out    <= 1'b0;
      carry_out <= 1'b0;
    end else begin
      en_out    <= ctl.conv & en_in;
      carry_out <= ctl.conv & en_in & ge;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.conv && en_in) begin
      digit <= dbl_red[rdc_pkg::DIGIT_BITS-1:0];
    end else if (ctl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

// File: design/radix_digit_converter.sv
// Flow: after accept the value bits enter MSB first through the conversion row
// (carries ripple one cell per cycle), then leading zero digits are skipped by
// shifting the row, then the remaining digits are emitted, held while the output stalls.
// One item at a time: no new item is accepted until the block is back in idle after
// its last digit; skipped and emitted digits always add up to VALUE_BITS.
// Reset: synchronous, active high; clears control state and the output valid.
module radix_digit_converter (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  rdc_pkg::item_t  item,
  output logic            digit_valid,
  input  logic            digit_stall,
  output rdc_pkg::digit_t digit
);

  localparam int NC    = rdc_pkg::VALUE_BITS;
  localparam int CNT_W = $clog2(2 * NC);
  localparam int REM_W = $clog2(NC + 1);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(2 * NC - 2);
  localparam logic [CNT_W-1:0] FEED_LEN  = CNT_W'(NC);
  localparam logic [REM_W-1:0] REM_FULL  = REM_W'(NC);
  localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                     state;
  logic [CNT_W-1:0]               cnt;
  logic [REM_W-1:0]               remaining;
  logic [NC-1:0]                  value_sr;
  logic [rdc_pkg::RADIX_BITS-1:0] radix_r;

  logic                           accept;
  logic                           out_free;
  logic                           out_take;
  logic                           skip_shift;
  logic                           emit_load;
  rdc_pkg::cell_ctl_t             ctl;

  logic [rdc_pkg::DIGIT_BITS-1:0] cell_digit [NC];
  logic                           cell_en    [NC];
  logic                           cell_carry [NC];
  logic [rdc_pkg::DIGIT_BITS-1:0] top_digit;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_take   = digit_valid && !digit_stall;
  assign out_free   = !digit_valid || !digit_stall;
  assign top_digit  = cell_digit[NC-1];

  assign skip_shift = (state == S_SKIP) && (top_digit == '0) && (remaining > REM_ONE);
  assign emit_load  = (state == S_EMIT) && (remaining != '0) && out_free;

  always_comb begin
    ctl.clear = accept;
    ctl.conv  = (state == S_CONV);
    ctl.shift = skip_shift || emit_load;
    ctl.radix = radix_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < NC; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        rdc_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctl       (ctl),
          .en_in     (cnt < FEED_LEN),
          .carry_in  (value_sr[NC-1]),
          .digit_in  ('0),
          .digit     (cell_digit[gi]),
          .en_out    (cell_en[gi]),
          .carry_out (cell_carry[gi])
        );
      end else begin : g_rest
        rdc_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctl       (ctl),
          .en_in     (cell_en[gi-1]),
          .carry_in  (cell_carry[gi-1]),
          .digit_in  (cell_digit[gi-1]),
          .digit     (cell_digit[gi]),
          .en_out    (cell_en[gi]),
          .carry_out (cell_carry[gi])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      remaining <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CONV_LAST) begin
            remaining <= REM_FULL;
            state     <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_shift) remaining <= remaining - REM_ONE;
          else            state     <= S_EMIT;
        end
        S_EMIT: begin
          if (remaining == '0) state <= S_IDLE;
          else if (out_free)   remaining <= remaining - REM_ONE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_sr <= item.value;
      radix_r  <= rdc_pkg::clamp_radix(item.radix);
    end else if (state == S_CONV) begin
      value_sr <= {value_sr[NC-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (emit_load) begin
      digit_valid <= 1'b1;
    end else if (out_take) begin
      digit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      digit.digit_value <= top_digit;
      digit.digit_char  <= rdc_pkg::digit_ascii(top_digit);
      digit.last_digit  <= (remaining == REM_ONE);
    end
  end

endmodule

// File: verif/radix_digit_converter_test.sv
// Self-checking testbench for radix_digit_converter: value/radix beats in,
// digit beats out, checked against a local digit expansion.
// Depends on rdc_pkg and the radix_digit_converter RTL.
`timescale 1ns / 1ps

module radix_digit_converter_test;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 148;
  localparam int IDLE_PCT     = 36;
  localparam int HOLD_AT_ITEM = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_FIRST   = 100;
  localparam int CALM_LAST    = 130;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [rdc_pkg::CHAR_BITS-1:0] ASCII_ZERO    = 7'h30;
  localparam logic [rdc_pkg::CHAR_BITS-1:0] ASCII_UPPER_A = 7'h41;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_stall;
  rdc_pkg::item_t  item = '0;
  logic            digit_valid;
  logic            digit_stall = 1'b0;
  rdc_pkg::digit_t digit;

  rdc_pkg::item_t  conversion_requests[$];
  rdc_pkg::digit_t expected_digits[$];

  int items_queued = 0;
  int items_sent = 0;
  int digits_checked = 0;
  int mismatches = 0;
  int leftover = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  radix_digit_converter uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit       (digit)
  );

  always #CLK_HALF clk = ~clk;

  // Expected digits of one value, most significant first.
  function automatic void expand_digits(input rdc_pkg::item_t it);
    logic [rdc_pkg::VALUE_BITS-1:0] rest;
    logic [rdc_pkg::RADIX_BITS-1:0] base;
    logic [rdc_pkg::DIGIT_BITS-1:0] low_first[$];
    rdc_pkg::digit_t d;
    base = it.radix;
    if (base < 5'd2) base = 5'd2;
    if (base > 5'd16) base = 5'd16;
    rest = it.value;
    do begin
      low_first.push_back(rdc_pkg::DIGIT_BITS'(rest % base));
      rest = rest / base;
    end while (rest != 0);
    for (int k = low_first.size() - 1; k >= 0; k--) begin
      d.digit_value = low_first[k];
      d.digit_char  = (low_first[k] < 4'd10)
                    ? ASCII_ZERO + rdc_pkg::CHAR_BITS'(low_first[k])
                    : ASCII_UPPER_A + rdc_pkg::CHAR_BITS'(low_first[k] - 4'd10);
      d.last_digit  = (k == 0);
      expected_digits.push_back(d);
    end
  endfunction

  function automatic void queue_item(input logic [rdc_pkg::VALUE_BITS-1:0] v,
                                     input logic [rdc_pkg::RADIX_BITS-1:0] r);
    rdc_pkg::item_t it;
    it.value = v;
    it.radix = r;
    conversion_requests.push_back(it);
    items_queued++;
  endfunction

  // Mostly legal bases; values spread over every digit count.
  function automatic rdc_pkg::item_t random_item();
    rdc_pkg::item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) it.radix = rdc_pkg::RADIX_BITS'($urandom_range(16, 2));
    else if (pick < 88) it.radix = rdc_pkg::RADIX_BITS'($urandom_range(1, 0));
    else it.radix = rdc_pkg::RADIX_BITS'($urandom_range(31, 17));
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.value = rdc_pkg::VALUE_BITS'($urandom);
    end else if (pick < 70) begin
      it.value = rdc_pkg::VALUE_BITS'($urandom) >> $urandom_range(rdc_pkg::VALUE_BITS - 1);
    end else if (pick < 85) begin
      it.value = rdc_pkg::VALUE_BITS'($urandom_range(255));
    end else if (pick < 92) begin
      it.value = '0;
    end else begin
      it.value = {rdc_pkg::VALUE_BITS{1'b1}} >> $urandom_range(rdc_pkg::VALUE_BITS - 1);
    end
    return it;
  endfunction

  function automatic void note_mismatch(input string what, input rdc_pkg::digit_t exp_d,
                                        input rdc_pkg::digit_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH %s: expected val=%0d char=%0d last=%0b, got val=%0d char=%0d last=%0b",
               what, exp_d.digit_value, exp_d.digit_char, exp_d.last_digit,
               got.digit_value, got.digit_char, got.last_digit);
  endfunction

  function automatic bit calm_window();
    return items_sent >= CALM_FIRST && items_sent < CALM_LAST;
  endfunction

  // Driver: one beat per accepted item, payload held while stalled.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) begin
        expand_digits(item);
        items_sent <= items_sent + 1;
      end
      if (conversion_requests.size() != 0 &&
          (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
        item_valid <= 1'b1;
        item <= conversion_requests.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off so the block backs up into its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: check each digit beat, then pick the next stall.
  always @(posedge clk) begin
    rdc_pkg::digit_t exp_d;
    if (rst) begin
      digit_stall <= 1'b0;
    end else begin
      if (digit_valid && !digit_stall) begin
        digits_checked++;
        if (expected_digits.size() == 0) begin
          note_mismatch("unexpected digit", '0, digit);
        end else begin
          exp_d = expected_digits.pop_front();
          if (digit.digit_value !== exp_d.digit_value ||
              digit.digit_char !== exp_d.digit_char ||
              digit.last_digit !== exp_d.last_digit)
            note_mismatch("digit", exp_d, digit);
        end
      end
      if (hold_left > 0) digit_stall <= 1'b1;
      else if (calm_window()) digit_stall <= 1'b0;
      else digit_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digits still expected",
               cycle_count, expected_digits.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // Directed: zero, full-width values, clamped bases, every hex digit.
    queue_item(30'd0, 5'd10);
    queue_item(30'd0, 5'd0);
    queue_item(30'd0, 5'd31);
    queue_item(30'd1, 5'd2);
    queue_item(30'h3FFFFFFF, 5'd2);
    queue_item(30'h3FFFFFFF, 5'd16);
    queue_item(30'h3FFFFFFF, 5'd3);
    queue_item(30'h3FFFFFFF, 5'd10);
    queue_item(30'd1, 5'd1);
    queue_item(30'd5, 5'd0);
    queue_item(30'd255, 5'd17);
    queue_item(30'd255, 5'd31);
    queue_item(30'd1000, 5'd10);
    queue_item(30'd999, 5'd10);
    queue_item(30'd1024, 5'd2);
    queue_item(30'd1023, 5'd2);
    queue_item(30'h0FEDCBA9, 5'd16);
    queue_item(30'h3ABCDEF0, 5'd16);
    queue_item(30'h12345678, 5'd16);
    queue_item(30'd13, 5'd14);
    queue_item(30'd14, 5'd15);
    queue_item(30'd4095, 5'd12);
    queue_item(30'h2AAAAAAA, 5'd4);
    queue_item(30'h15555555, 5'd2);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Sender pause: let every directed digit come back first.
    while (items_sent < items_queued || expected_digits.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      conversion_requests.push_back(random_item());
      items_queued++;
    end

    while (items_sent < items_queued || expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    leftover = expected_digits.size();
    $display("Converted %0d values into %0d checked digits (bases 0..31, zero and full width)",
             items_sent, digits_checked);
    $display("Mismatches: %0d, digits never seen: %0d", mismatches, leftover);
    if (mismatches == 0 && leftover == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rdc_pkg.sv
design/rdc_cell.sv
design/radix_digit_converter.sv
verif/radix_digit_converter_test.sv
